// ----- sv/mwo_pkg.sv -----
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types, register codes, reset values and the quarter-sine generator.
// ----------------------------------------------------------------------------
`default_nettype none
package mwo_pkg;

  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 18;
  localparam int WAVE_W   = 3;
  localparam int FREQ_W   = 16;
  localparam int RATE_W   = 18;
  localparam int VOL_W    = 8;
  localparam int IDX_W    = 32;
  localparam int SMP_W    = 18;
  localparam int TAB_W    = 17;
  localparam int PROD_W   = FREQ_W + IDX_W;

  localparam logic [CFG_AW-1:0] REG_WAVEFORM  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FREQUENCY = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RATE      = 2'd2;
  localparam logic [CFG_AW-1:0] REG_VOLUME    = 2'd3;

  localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
  localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd1;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd2;
  localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd3;

  localparam logic [WAVE_W-1:0] RST_WAVEFORM = WAVE_SINE;
  localparam logic [FREQ_W-1:0] RST_FREQ     = 16'd440;
  localparam logic [RATE_W-1:0] RST_RATE     = 18'd44100;
  localparam logic [VOL_W-1:0]  RST_VOLUME   = 8'd255;
  localparam logic [RATE_W-1:0] RST_PERIOD   = RST_RATE / RATE_W'(RST_FREQ);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic              busy;
    logic [RATE_W-1:0] period;
  } period_t;

  // Taylor series of sin(x), x in Q30, truncated each step, result in Q16
  function automatic logic [TAB_W-1:0] sin_from_x(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] rnd;
    term = x;
    sum  = x;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd6;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd20;
    sum  = sum + term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd42;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd72;
    sum  = sum + term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd110;
    sum  = sum - term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd156;
    sum  = sum + term;
    term = (term * x) >> 30;
    term = ((term * x) >> 30) / 64'd210;
    sum  = sum - term;
    rnd  = (sum + 64'd8192) >> 14;
    return rnd[TAB_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/multi_waveform_oscillator.sv -----
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Sine, sawtooth, square and triangle samples from a running sample index.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless out_stall or the period divider holds
// the input. An index passes the input and multiply stages, the modulo and
// fraction divider pipelines, the table and scaling registers and the output
// register. After a write to any register the input stalls while the period
// divider runs. Reset restores register defaults and empties the pipeline.
`default_nettype none
module multi_waveform_oscillator #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [mwo_pkg::IDX_W-1:0]         in_sample_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [mwo_pkg::SMP_W-1:0]       out_sample,
  output logic                                   out_error,
  input  wire logic                              cfg_we,
  input  wire logic [mwo_pkg::CFG_AW-1:0]        cfg_index,
  input  wire logic [mwo_pkg::CFG_DW-1:0]        cfg_wdata
);

  localparam int KW  = $clog2(SINE_TABLE_DEPTH);
  localparam int AW  = KW + 2;
  localparam int NF  = (AW > 10) ? AW : 10;
  localparam int RW  = mwo_pkg::RATE_W;
  localparam int FW  = mwo_pkg::FREQ_W;
  localparam int PW  = mwo_pkg::PROD_W;
  localparam int IW  = mwo_pkg::IDX_W;
  localparam int TBW = mwo_pkg::TAB_W;
  localparam int SW  = mwo_pkg::SMP_W;
  localparam int VW  = mwo_pkg::VOL_W;

  // configuration registers
  logic [mwo_pkg::WAVE_W-1:0] wave_r;
  logic [FW-1:0]              freq_r;
  logic [RW-1:0]              rate_r;
  logic [VW-1:0]              vol_r;
  logic [FW-1:0]              freq_nxt;
  logic [RW-1:0]              rate_nxt;

  always_comb begin
    freq_nxt = freq_r;
    rate_nxt = rate_r;
    if (cfg_we && cfg_index == mwo_pkg::REG_FREQUENCY) freq_nxt = cfg_wdata[FW-1:0];
    if (cfg_we && cfg_index == mwo_pkg::REG_RATE)      rate_nxt = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= mwo_pkg::RST_WAVEFORM;
      freq_r <= mwo_pkg::RST_FREQ;
      rate_r <= mwo_pkg::RST_RATE;
      vol_r  <= mwo_pkg::RST_VOLUME;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mwo_pkg::REG_WAVEFORM:  wave_r <= cfg_wdata[mwo_pkg::WAVE_W-1:0];
        mwo_pkg::REG_FREQUENCY: freq_r <= freq_nxt;
        mwo_pkg::REG_RATE:      rate_r <= rate_nxt;
        mwo_pkg::REG_VOLUME:    vol_r  <= cfg_wdata[VW-1:0];
        default: ;
      endcase
    end
  end

  mwo_pkg::period_t per_st;

  mwo_period u_period (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_we),
    .dividend (rate_nxt),
    .divisor  (freq_nxt),
    .st       (per_st)
  );

  logic [RW-1:0] period;
  logic [RW-1:0] half;
  assign period = per_st.period;
  assign half   = {1'b0, period[RW-1:1]};

  // pipeline advance
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv || per_st.busy;

  // input and multiply stages
  logic          v0_r, v1_r;
  logic [IW-1:0] idx0_r, idx1_r;
  logic [PW-1:0] prod1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid && !per_st.busy;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx0_r  <= in_sample_index;
      idx1_r  <= idx0_r;
      prod1_r <= PW'(freq_r) * PW'(idx0_r);
    end
  end

  // position within the period and phase within the sample rate
  logic [RW-1:0] m_pos;
  logic [RW-1:0] r_ph;
  logic          vb_mod;

  mwo_divpipe #(.NB(PW), .W(RW), .TW(1)) u_mod_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dividend (PW'(idx1_r)),
    .rem_in   ('0),
    .divisor  (period),
    .tag_in   (1'b0),
    .rem_out  (m_pos),
    .quo_out  (),
    .tag_out  ()
  );

  mwo_divpipe #(.NB(PW), .W(RW), .TW(1)) u_mod_ph (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dividend (prod1_r),
    .rem_in   ('0),
    .divisor  (rate_r),
    .tag_in   (v1_r),
    .rem_out  (r_ph),
    .quo_out  (),
    .tag_out  (vb_mod)
  );

  // fractions: floor(2^NF * m / P) and floor(2^NF * r / rate)
  logic [NF-1:0] qa;
  logic [NF-1:0] qb;
  logic          lt_half;
  logic          vb_frac;

  mwo_divpipe #(.NB(NF), .W(RW), .TW(1)) u_frac_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dividend ('0),
    .rem_in   (m_pos),
    .divisor  (period),
    .tag_in   (m_pos < half),
    .rem_out  (),
    .quo_out  (qa),
    .tag_out  (lt_half)
  );

  mwo_divpipe #(.NB(NF), .W(RW), .TW(1)) u_frac_ph (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .dividend ('0),
    .rem_in   (r_ph),
    .divisor  (rate_r),
    .tag_in   (vb_mod),
    .rem_out  (),
    .quo_out  (qb),
    .tag_out  (vb_frac)
  );

  // quarter-wave table, registered read
  logic [TBW-1:0] qtab [SINE_TABLE_DEPTH+1];
  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [63:0] XK = (mwo_pkg::HALF_PI_Q30 * k) / SINE_TABLE_DEPTH;
    assign qtab[k] = mwo_pkg::sin_from_x(XK);
  end

  logic [NF-1:0] a_full;
  logic [AW-1:0] a_ph;
  logic [KW:0]   k_idx;
  logic [KW:0]   tab_addr;
  assign a_full   = qb >> (NF - AW);
  assign a_ph     = a_full[AW-1:0];
  assign k_idx    = {1'b0, a_ph[KW-1:0]};
  assign tab_addr = a_ph[KW] ? ((KW+1)'(SINE_TABLE_DEPTH) - k_idx) : k_idx;

  logic           v2_r, v3_r;
  logic [TBW-1:0] tab2_r;
  logic           neg2_r, neg3_r;
  logic [NF-1:0]  qa2_r, qa3_r;
  logic           lt2_r, lt3_r;
  logic [TBW-1:0] mag3_r;
  logic [VW+TBW:0] scaled;

  assign scaled = (VW+TBW+1)'(vol_r) * (VW+TBW+1)'(tab2_r) + (VW+TBW+1)'(128);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v2_r <= vb_frac;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tab2_r <= qtab[tab_addr];
      neg2_r <= a_ph[AW-1];
      qa2_r  <= qa;
      lt2_r  <= lt_half;
      mag3_r <= scaled[TBW+7:8];
      neg3_r <= neg2_r;
      qa3_r  <= qa2_r;
      lt3_r  <= lt2_r;
    end
  end

  // waveform select
  logic [NF-1:0]        q9_full, q10_full;
  logic signed [SW-1:0] q9, q10, sine_v, saw_v, sq_v, tri_v, smp_nxt;
  logic                 err_nxt;

  always_comb begin
    q9_full  = qa3_r >> (NF - 9);
    q10_full = qa3_r >> (NF - 10);
    q9       = SW'(q9_full[8:0]);
    q10      = SW'(q10_full[9:0]);
    sine_v   = neg3_r ? -$signed(SW'(mag3_r)) : $signed(SW'(mag3_r));
    saw_v    = SW'(256) - q9;
    sq_v     = lt3_r ? SW'(256) : -SW'(256);
    tri_v    = lt3_r ? (q10 - SW'(256)) : (SW'(768) - q10);
    err_nxt  = (wave_r > mwo_pkg::WAVE_TRIANGLE) || (period == '0);
    case (wave_r)
      mwo_pkg::WAVE_SINE:   smp_nxt = sine_v;
      mwo_pkg::WAVE_SAW:    smp_nxt = saw_v;
      mwo_pkg::WAVE_SQUARE: smp_nxt = sq_v;
      default:              smp_nxt = tri_v;
    endcase
    if (err_nxt) smp_nxt = '0;
  end

  logic signed [SW-1:0] smp_r;
  logic                 err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      smp_r <= smp_nxt;
      err_r <= err_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = smp_r;
  assign out_error  = err_r;

  a_busy_stall : assert property (@(posedge clk) disable iff (!rst_n)
    per_st.busy |-> in_stall) else $error("input taken while period divider busy");

  a_cfg_stall : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall) else $error("no stall after register write");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error) |-> (out_sample == '0)) else $error("error word not zero");

endmodule
`default_nettype wire

// ----- sv/mwo_period.sv -----
// ----------------------------------------------------------------------------
// mwo_period
// Iterative restoring divider for the tone period, rate / frequency.
// ----------------------------------------------------------------------------
`default_nettype none
module mwo_period (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mwo_pkg::RATE_W-1:0] dividend,
  input  wire logic [mwo_pkg::FREQ_W-1:0] divisor,
  output mwo_pkg::period_t               st
);

  localparam int RW = mwo_pkg::RATE_W;
  localparam int FW = mwo_pkg::FREQ_W;
  localparam int CW = $clog2(RW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [RW-1:0] dq_r;
  logic [FW-1:0] rem_r;
  logic [FW-1:0] div_r;
  logic [RW-1:0] per_r;

  logic [FW:0]   trial;
  logic          ge;
  logic [FW:0]   diff;

  always_comb begin
    trial = {rem_r, dq_r[RW-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      per_r  <= mwo_pkg::RST_PERIOD;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(RW);
      dq_r   <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[FW-1:0] : trial[FW-1:0];
      dq_r  <= {dq_r[RW-2:0], ge};
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
        // zero frequency gives a zero period
        per_r  <= (div_r == '0) ? '0 : {dq_r[RW-2:0], ge};
      end
    end
  end

  assign st.busy   = busy_r;
  assign st.period = per_r;

endmodule
`default_nettype wire

// ----- sv/mwo_divpipe.sv -----
// ----------------------------------------------------------------------------
// mwo_divpipe
// Pipelined restoring long division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module mwo_divpipe #(
  parameter int NB = 32,
  parameter int W  = 18,
  parameter int TW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic [NB-1:0] dividend,
  input  wire logic [W-1:0]  rem_in,
  input  wire logic [W-1:0]  divisor,
  input  wire logic [TW-1:0] tag_in,
  output logic      [W-1:0]  rem_out,
  output logic      [NB-1:0] quo_out,
  output logic      [TW-1:0] tag_out
);

  logic [W-1:0]  rem_r [NB];
  logic [NB-1:0] dq_r  [NB];
  logic [TW-1:0] tag_r [NB];

  for (genvar i = 0; i < NB; i++) begin : g_stage
    logic [W-1:0]  rem_i;
    logic [NB-1:0] dq_i;
    logic [TW-1:0] tag_i;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_i = rem_in;
      assign dq_i  = dividend;
      assign tag_i = tag_in;
    end else begin : g_next
      assign rem_i = rem_r[i-1];
      assign dq_i  = dq_r[i-1];
      assign tag_i = tag_r[i-1];
    end

    always_comb begin
      trial = {rem_i, dq_i[NB-1]};
      ge    = trial >= {1'b0, divisor};
      diff  = trial - {1'b0, divisor};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i] <= '0;
      end else if (adv) begin
        tag_r[i] <= tag_i;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i] <= ge ? diff[W-1:0] : trial[W-1:0];
        dq_r[i]  <= {dq_i[NB-2:0], ge};
      end
    end
  end

  assign rem_out = rem_r[NB-1];
  assign quo_out = dq_r[NB-1];
  assign tag_out = tag_r[NB-1];

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_waveform_oscillator: a directed table, then
// corner and random register settings and random sample indices, each result
// checked against a typed row or a predictor of sine, sawtooth, square, triangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import mwo_pkg::*;

  localparam int DEPTH = 1024;

  typedef struct {
    logic [SMP_W-1:0] sample;
    logic             error;
  } sample_word_t;

  typedef struct {
    bit               skip_cfg;
    logic [WAVE_W-1:0] wave;
    logic [FREQ_W-1:0] freq;
    logic [RATE_W-1:0] rate;
    logic [VOL_W-1:0]  vol;
    logic [IDX_W-1:0]  idx;
    bit               typed;
    logic [SMP_W-1:0] t_sample;
    logic             t_error;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [IDX_W-1:0] in_sample_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SMP_W-1:0] out_sample;
  logic out_error;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  logic [WAVE_W-1:0] wave_r = RST_WAVEFORM;
  logic [FREQ_W-1:0] freq_r = RST_FREQ;
  logic [RATE_W-1:0] rate_r = RST_RATE;
  logic [VOL_W-1:0]  vol_r  = RST_VOLUME;

  longint unsigned quarter_sine[DEPTH+1];
  sample_word_t pending_samples[$];
  int  errors = 0;
  int  idle_pct = 20;
  bit  calm = 0;
  bit  hold_req = 0;

  always #5 clk = ~clk;

  multi_waveform_oscillator i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_sample_index,
    .out_valid, .out_stall, .out_sample, .out_error,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  function automatic void build_quarter_sine();
    longint unsigned x, term, sum;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (64'd1686629713 * k) / DEPTH;
      term = x;
      sum = x;
      for (int n = 3; n <= 15; n += 2) begin
        term = (term * x) >> 30;
        term = ((term * x) >> 30) / ((n - 1) * n);
        if (((n - 3) / 2) % 2 == 0) sum = sum - term;
        else sum = sum + term;
      end
      quarter_sine[k] = (sum + 8192) >> 14;
    end
  endfunction

  function automatic sample_word_t oscillator_sample(logic [IDX_W-1:0] idx);
    sample_word_t w;
    longint unsigned period, m, half, r, a, q, k, s;
    longint v;
    v = 0;
    w.error = 1'b0;
    period = (freq_r != 0) ? rate_r / freq_r : 0;
    if (wave_r > WAVE_TRIANGLE || period == 0) begin
      w.error = 1'b1;
    end else begin
      m = idx % period;
      half = period / 2;
      case (wave_r)
        WAVE_SINE: begin
          r = (longint'(freq_r) * idx) % rate_r;
          a = (r * 4 * DEPTH) / rate_r;
          q = (a / DEPTH) & 3;
          k = a % DEPTH;
          s = q[0] ? quarter_sine[DEPTH - k] : quarter_sine[k];
          v = (vol_r * s + 128) >> 8;
          if (q[1]) v = -v;
        end
        WAVE_SAW: v = 256 - longint'((512 * m) / period);
        WAVE_SQUARE: v = (m < half) ? 256 : -256;
        default: begin
          if (m < half) v = -256 + longint'((1024 * m) / period);
          else v = 768 - longint'((1024 * m) / period);
        end
      endcase
    end
    w.sample = v[SMP_W-1:0];
    return w;
  endfunction

  // drain, then write all four registers with junk in the unused upper bits
  task automatic load_settings(logic [WAVE_W-1:0] w, logic [FREQ_W-1:0] f,
                               logic [RATE_W-1:0] r, logic [VOL_W-1:0] v);
    logic [CFG_DW-1:0] junk;
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      junk = CFG_DW'($urandom);
      cfg_we <= 1'b1;
      cfg_index <= CFG_AW'(i);
      case (CFG_AW'(i))
        REG_WAVEFORM:  cfg_wdata <= {junk[CFG_DW-1:WAVE_W], w};
        REG_FREQUENCY: cfg_wdata <= {junk[CFG_DW-1:FREQ_W], f};
        REG_RATE:      cfg_wdata <= r;
        default:       cfg_wdata <= {junk[CFG_DW-1:VOL_W], v};
      endcase
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    wave_r = w;
    freq_r = f;
    rate_r = r;
    vol_r = v;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_index(logic [IDX_W-1:0] idx, bit typed = 0,
                            logic [SMP_W-1:0] ts = '0, logic te = 1'b0);
    sample_word_t w;
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_index <= idx;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      w.sample = ts;
      w.error = te;
    end else begin
      w = oscillator_sample(idx);
    end
    pending_samples.push_back(w);
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    sample_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected word: sample %0d error %0b", out_sample, out_error);
        errors++;
      end else begin
        w = pending_samples.pop_front();
        if (out_sample !== w.sample) begin
          $error("sample: expected %0d, got %0d", $signed(w.sample), out_sample);
          errors++;
        end
        if (out_error !== w.error) begin
          $error("error: expected %0b, got %0b", w.error, out_error);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #4ms;
    $display("FAIL multi_waveform_oscillator");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [WAVE_W-1:0] w;
    logic [FREQ_W-1:0] f;
    logic [RATE_W-1:0] r;
    logic [IDX_W-1:0] idx;
    build_quarter_sine();
    //         skip wave           freq    rate       vol    idx            typed
    rows = '{
      '{1, WAVE_SINE,     440,   44100,  255, 0,             1, 18'd0,   1'b0},
      '{1, WAVE_SINE,     440,   44100,  255, 25,            0, 0, 0},
      '{1, WAVE_SINE,     440,   44100,  255, 32'hFFFFFFFF,  0, 0, 0},
      '{0, 3'd4,          440,   44100,  255, 7,             1, 18'd0,   1'b1},
      '{0, 3'd7,          1,     262143, 0,   32'hFFFFFFFF,  1, 18'd0,   1'b1},
      '{0, WAVE_SINE,     0,     44100,  255, 3,             1, 18'd0,   1'b1},
      '{0, WAVE_SAW,      100,   0,      255, 3,             1, 18'd0,   1'b1},
      '{0, WAVE_SQUARE,   65535, 1000,   255, 3,             1, 18'd0,   1'b1},
      '{0, WAVE_SAW,      1,     262143, 255, 0,             1, 18'd256, 1'b0},
      '{0, WAVE_SAW,      1,     262143, 255, 262142,        0, 0, 0},
      '{0, WAVE_SQUARE,   7,     100,    255, 0,             1, 18'd256, 1'b0},
      '{0, WAVE_SQUARE,   7,     100,    255, 13,            0, 0, 0},
      '{0, WAVE_TRIANGLE, 3,     100,    255, 0,             1, -18'sd256, 1'b0},
      '{0, WAVE_TRIANGLE, 3,     100,    255, 20,            0, 0, 0},
      '{0, WAVE_SQUARE,   65535, 65535,  255, 9,             1, -18'sd256, 1'b0},
      '{0, WAVE_SINE,     440,   44100,  0,   77,            1, 18'd0,   1'b0},
      '{0, WAVE_SINE,     65535, 262143, 255, 32'hFFFFFFFF,  0, 0, 0},
      '{0, WAVE_SINE,     1,     4,      255, 1,             0, 0, 0},
      '{0, WAVE_SINE,     1,     4,      128, 3,             0, 0, 0},
      '{0, WAVE_TRIANGLE, 65535, 262143, 255, 32'hFFFFFFFF,  0, 0, 0}
    };
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) begin
      if (!rows[i].skip_cfg &&
          {rows[i].wave, rows[i].freq, rows[i].rate, rows[i].vol} !=
          {wave_r, freq_r, rate_r, vol_r})
        load_settings(rows[i].wave, rows[i].freq, rows[i].rate, rows[i].vol);
      send_index(rows[i].idx, rows[i].typed, rows[i].t_sample, rows[i].t_error);
    end

    for (int ph = 0; ph < 22; ph++) begin
      case (ph)
        0: load_settings(WAVE_SINE, 16'hFFFF, 18'h3FFFF, 8'hFF);
        1: load_settings(WAVE_SAW, 16'd1, 18'h3FFFF, 8'h00);
        2: load_settings(WAVE_TRIANGLE, 16'hFFFF, 18'h3FFFF, 8'hAA);
        3: load_settings(WAVE_SQUARE, 16'd1, 18'd1, 8'h55);
        default: begin
          w = (ph % 9 == 8) ? WAVE_W'($urandom_range(4, 7)) : WAVE_W'(ph % 4);
          r = RATE_W'($urandom_range(1, 262143));
          if ($urandom_range(0, 9) == 0) f = FREQ_W'($urandom);
          else f = FREQ_W'($urandom_range(1, (r < 65535) ? r : 65535));
          load_settings(w, f, r, VOL_W'($urandom));
        end
      endcase
      calm = (ph >= 19);
      idle_pct = (ph % 5 == 2) ? 0 : 20;
      if (ph == 6) hold_req = 1;
      repeat (50) begin
        case ($urandom_range(0, 2))
          0: idx = $urandom;
          1: idx = $urandom_range(0, 2000);
          default: idx = 32'hFFFFFFFF - $urandom_range(0, 1000);
        endcase
        send_index(idx);
      end
    end

    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (errors == 0) $display("PASS multi_waveform_oscillator");
    else $display("FAIL multi_waveform_oscillator");
    $finish;
  end
endmodule

// ----- files.f -----
sv/mwo_pkg.sv
sv/mwo_period.sv
sv/mwo_divpipe.sv
sv/multi_waveform_oscillator.sv
test/tb_top.sv
